[rtl/bmp_pkg.sv]
// Shared types, constants and the colour palette ROM for the bar meter drawer.
// Depends on nothing; every other file in rtl uses it by scoped names.
`default_nettype none

package bmp_pkg;

  // Kinds of work that the front part hands to the back part.
  typedef enum logic [1:0] {
    KIND_PALETTE,
    KIND_TICK,
    KIND_SAMPLE
  } kind_e;

  // One queued word between front and back.
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  bar;
    logic [2:0]  level;
  } entry_t;

  // Configuration registers as seen by the back part.
  typedef struct packed {
    logic [7:0] fill_hold;
    logic [7:0] peak_hold;
    logic [7:0] fill_period;
    logic [7:0] peak_period;
  } cfg_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_FILL_HOLD   = 2'd0;
  localparam logic [1:0] REG_PEAK_HOLD   = 2'd1;
  localparam logic [1:0] REG_FILL_PERIOD = 2'd2;
  localparam logic [1:0] REG_PEAK_PERIOD = 2'd3;

  // Reset values of the registers and of the palette selector.
  localparam logic [7:0] FILL_HOLD_RST   = 8'd6;
  localparam logic [7:0] PEAK_HOLD_RST   = 8'd12;
  localparam logic [7:0] FILL_PERIOD_RST = 8'd3;
  localparam logic [7:0] PEAK_PERIOD_RST = 8'd10;
  localparam logic [1:0] PALETTE_RST     = 2'd2;

  // Geometry and fixed colours.
  localparam int unsigned ROWS        = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [2:0]  TOP_ROW     = 3'd7;
  localparam logic [23:0] PEAK_COLOUR = 24'hFF0000;

  // Palette ROM: colour as {red, green, blue} for a palette and a row.
  function automatic logic [23:0] palette_colour(logic [1:0] pal, logic [2:0] row);
    logic [23:0] c;
    c = 24'h000000;
    case ({pal, row})
      5'd0:  c = 24'h00FF00;
      5'd1:  c = 24'h00FF00;
      5'd2:  c = 24'h00FF00;
      5'd3:  c = 24'h00FF00;
      5'd4:  c = 24'h00FF00;
      5'd5:  c = 24'hFF8000;
      5'd6:  c = 24'hFF8000;
      5'd7:  c = 24'hFF0000;
      5'd8:  c = 24'h0000FF;
      5'd9:  c = 24'h2200DD;
      5'd10: c = 24'h4400BB;
      5'd11: c = 24'h660099;
      5'd12: c = 24'h990066;
      5'd13: c = 24'hBB0044;
      5'd14: c = 24'hDD0022;
      5'd15: c = 24'hFF0000;
      5'd16: c = 24'h00FF00;
      5'd17: c = 24'h00DD22;
      5'd18: c = 24'h00BB44;
      5'd19: c = 24'h009966;
      5'd20: c = 24'h007788;
      5'd21: c = 24'h0055AA;
      5'd22: c = 24'h0033CC;
      5'd23: c = 24'h0011EE;
      5'd24: c = 24'hB20E00;
      5'd25: c = 24'hBD2B00;
      5'd26: c = 24'hC84800;
      5'd27: c = 24'hD36400;
      5'd28: c = 24'hDE8100;
      5'd29: c = 24'hE99E00;
      5'd30: c = 24'hF4BA00;
      5'd31: c = 24'hFFD700;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/bmp_front.sv]
// Front part of the bar meter drawer: accepts input words and classifies them.
// Uses bmp_pkg for the queue word type; feeds bmp_queue.
`default_nettype none

module bmp_front #(
  parameter int unsigned NUM_BARS = 16
) (
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            cmd_i,
  input  wire logic [3:0]      bar_index_i,
  input  wire logic [7:0]      sample_level_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output bmp_pkg::entry_t      q_entry_o
);

  logic accept;
  logic bar_ok;
  logic level_ok;

  // An input word is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign bar_ok   = ({1'b0, bar_index_i} < 5'(NUM_BARS));
  assign level_ok = (sample_level_i < 8'(bmp_pkg::ROWS));

  // Classify: palette advance, tick-only sample, or full sample. Samples for
  // bars that do not exist leave no trace and are not queued.
  always_comb begin
    q_entry_o.bar   = bar_index_i;
    q_entry_o.level = sample_level_i[2:0];
    if (cmd_i) begin
      q_entry_o.kind = bmp_pkg::KIND_PALETTE;
    end else if (level_ok) begin
      q_entry_o.kind = bmp_pkg::KIND_SAMPLE;
    end else begin
      q_entry_o.kind = bmp_pkg::KIND_TICK;
    end
    q_push_o = accept && (cmd_i || bar_ok);
  end

endmodule

`default_nettype wire

[rtl/bmp_queue.sv]
// Two-word queue that decouples the front part from the back part.
// Uses bmp_pkg for the word type.
`default_nettype none

module bmp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bmp_pkg::entry_t entry_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output bmp_pkg::entry_t      entry_o
);

  localparam int unsigned PtrW = $clog2(bmp_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(bmp_pkg::QUEUE_DEPTH + 1);

  bmp_pkg::entry_t mem_q [bmp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(bmp_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage words carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bmp_back.sv]
// Back part of the bar meter drawer: per-bar level state, decay check and
// pixel output. Uses bmp_pkg for types, constants and the palette ROM.
`default_nettype none

module bmp_back #(
  parameter int unsigned NUM_BARS     = 16,
  parameter int unsigned NUM_PALETTES = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bmp_pkg::cfg_t   cfg_i,
  input  wire logic            q_valid_i,
  input  wire bmp_pkg::entry_t q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 tile_select_o,
  output logic [5:0]           led_number_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 last_pixel_o
);

  localparam int unsigned BarW = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_UPD,
    S_EMIT
  } state_e;

  state_e      state_q;

  // Per-bar state.
  logic [2:0]  fill_row_q  [NUM_BARS];
  logic [2:0]  peak_row_q  [NUM_BARS];
  logic [7:0]  fill_hold_q [NUM_BARS];
  logic [7:0]  peak_hold_q [NUM_BARS];
  logic [7:0]  fill_tick_q [NUM_BARS];
  logic [7:0]  peak_tick_q [NUM_BARS];
  logic [NUM_BARS-1:0] force_q;
  logic [1:0]  palette_q;

  // Word being worked on.
  logic [3:0]  cur_bar_q;
  logic [2:0]  cur_lvl_q;
  logic [7:0]  fill_dvd_q;
  logic [7:0]  peak_dvd_q;
  logic [7:0]  fill_rem_q;
  logic [7:0]  peak_rem_q;
  logic [2:0]  step_q;
  logic [2:0]  fill_cnt_q;
  logic [2:0]  peak_pos_q;
  logic [2:0]  row_q;

  // Output register.
  logic        out_valid_q;
  logic        tile_q;
  logic [5:0]  led_q;
  logic [23:0] rgb_q;
  logic        last_q;

  logic [BarW-1:0] qb;
  logic [BarW-1:0] cb;
  logic [8:0]  fill_sh;
  logic [8:0]  peak_sh;
  logic [7:0]  fill_rem_d;
  logic [7:0]  peak_rem_d;
  logic [1:0]  pal_sel;
  logic [2:0]  lvl_eff;
  logic [2:0]  fill_old;
  logic [2:0]  peak_old;
  logic [2:0]  fill_new;
  logic [2:0]  peak_new;
  logic [7:0]  fill_hold_new;
  logic [7:0]  peak_hold_new;
  logic        fill_tick_clr;
  logic        peak_tick_clr;
  logic        out_load;
  logic [23:0] fill_colour;

  assign qb = q_entry_i.bar[BarW-1:0];
  assign cb = cur_bar_q[BarW-1:0];

  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign out_load = !out_valid_q || !out_stall_i;

  // One restoring-division step for each remainder. A zero period subtracts
  // nothing, so the remainder ends as the tick itself.
  always_comb begin
    fill_sh = {fill_rem_q, fill_dvd_q[7]};
    peak_sh = {peak_rem_q, peak_dvd_q[7]};
    if (fill_sh >= {1'b0, cfg_i.fill_period}) begin
      fill_rem_d = 8'(fill_sh - {1'b0, cfg_i.fill_period});
    end else begin
      fill_rem_d = fill_sh[7:0];
    end
    if (peak_sh >= {1'b0, cfg_i.peak_period}) begin
      peak_rem_d = 8'(peak_sh - {1'b0, cfg_i.peak_period});
    end else begin
      peak_rem_d = peak_sh[7:0];
    end
  end

  // Palette selector reduced by the number of palettes fitted.
  always_comb begin
    pal_sel = palette_q;
    for (int k = 0; k < 3; k++) begin
      if ({1'b0, pal_sel} >= 3'(NUM_PALETTES)) begin
        pal_sel = pal_sel - 2'(NUM_PALETTES);
      end
    end
  end

  assign fill_colour = bmp_pkg::palette_colour(pal_sel, row_q);

  // Fill and peak update for the current bar.
  always_comb begin
    lvl_eff       = force_q[cb] ? bmp_pkg::TOP_ROW : cur_lvl_q;
    fill_old      = fill_row_q[cb];
    peak_old      = peak_row_q[cb];
    fill_new      = fill_old;
    peak_new      = peak_old;
    fill_hold_new = fill_hold_q[cb];
    peak_hold_new = peak_hold_q[cb];
    fill_tick_clr = 1'b0;
    peak_tick_clr = 1'b0;

    if (fill_old < lvl_eff) begin
      fill_new      = lvl_eff;
      fill_hold_new = cfg_i.fill_hold;
    end else if (fill_hold_q[cb] != 8'd0) begin
      fill_hold_new = fill_hold_q[cb] - 8'd1;
    end else if ((fill_old != 3'd0) && (fill_rem_q == 8'd0)) begin
      fill_new      = fill_old - 3'd1;
      fill_tick_clr = 1'b1;
    end

    if (peak_old <= fill_new) begin
      peak_new      = fill_new;
      peak_hold_new = cfg_i.peak_hold;
    end else if (peak_hold_q[cb] != 8'd0) begin
      peak_hold_new = peak_hold_q[cb] - 8'd1;
    end else if ((peak_old != 3'd0) && (peak_rem_q == 8'd0)) begin
      peak_new      = peak_old - 3'd1;
      peak_tick_clr = 1'b1;
    end
  end

  // Sequencer, per-bar state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < NUM_BARS; i++) begin
        fill_row_q[i]  <= 3'd0;
        peak_row_q[i]  <= 3'd0;
        fill_hold_q[i] <= 8'd0;
        peak_hold_q[i] <= 8'd0;
        fill_tick_q[i] <= 8'd0;
        peak_tick_q[i] <= 8'd0;
      end
      force_q     <= '1;
      palette_q   <= bmp_pkg::PALETTE_RST;
      cur_bar_q   <= 4'd0;
      cur_lvl_q   <= 3'd0;
      fill_dvd_q  <= 8'd0;
      peak_dvd_q  <= 8'd0;
      fill_rem_q  <= 8'd0;
      peak_rem_q  <= 8'd0;
      step_q      <= 3'd0;
      fill_cnt_q  <= 3'd0;
      peak_pos_q  <= 3'd0;
      row_q       <= 3'd0;
      out_valid_q <= 1'b0;
      tile_q      <= 1'b0;
      led_q       <= 6'd0;
      rgb_q       <= 24'd0;
      last_q      <= 1'b0;
    end else begin
      // A taken output word leaves the register; while emitting, the next
      // pixel replaces it below.
      if (out_load && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            case (q_entry_i.kind)
              bmp_pkg::KIND_PALETTE: begin
                palette_q <= palette_q + 2'd1;
                force_q   <= '1;
              end
              bmp_pkg::KIND_TICK: begin
                fill_tick_q[qb] <= fill_tick_q[qb] + 8'd1;
                peak_tick_q[qb] <= peak_tick_q[qb] + 8'd1;
              end
              bmp_pkg::KIND_SAMPLE: begin
                fill_tick_q[qb] <= fill_tick_q[qb] + 8'd1;
                peak_tick_q[qb] <= peak_tick_q[qb] + 8'd1;
                fill_dvd_q      <= fill_tick_q[qb] + 8'd1;
                peak_dvd_q      <= peak_tick_q[qb] + 8'd1;
                fill_rem_q      <= 8'd0;
                peak_rem_q      <= 8'd0;
                step_q          <= 3'd0;
                cur_bar_q       <= q_entry_i.bar;
                cur_lvl_q       <= q_entry_i.level;
                state_q         <= S_DIV;
              end
              default: begin
              end
            endcase
          end
        end

        // Eight division steps give both tick remainders.
        S_DIV: begin
          fill_rem_q <= fill_rem_d;
          peak_rem_q <= peak_rem_d;
          fill_dvd_q <= {fill_dvd_q[6:0], 1'b0};
          peak_dvd_q <= {peak_dvd_q[6:0], 1'b0};
          step_q     <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            state_q <= S_UPD;
          end
        end

        S_UPD: begin
          fill_row_q[cb]  <= fill_new;
          peak_row_q[cb]  <= peak_new;
          fill_hold_q[cb] <= fill_hold_new;
          peak_hold_q[cb] <= peak_hold_new;
          force_q[cb]     <= 1'b0;
          if (fill_tick_clr) begin
            fill_tick_q[cb] <= 8'd0;
          end
          if (peak_tick_clr) begin
            peak_tick_q[cb] <= 8'd0;
          end
          fill_cnt_q <= fill_new;
          peak_pos_q <= peak_new;
          row_q      <= 3'd0;
          state_q    <= S_EMIT;
        end

        // Fill pixels from the bottom row up, then the peak pixel.
        S_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            tile_q      <= ~cur_bar_q[3];
            if (row_q < fill_cnt_q) begin
              led_q  <= {~row_q, cur_bar_q[2:0]};
              rgb_q  <= fill_colour;
              last_q <= 1'b0;
              row_q  <= row_q + 3'd1;
            end else begin
              led_q   <= {~peak_pos_q, cur_bar_q[2:0]};
              rgb_q   <= bmp_pkg::PEAK_COLOUR;
              last_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tile_select_o = tile_q;
  assign led_number_o  = led_q;
  assign red_o         = rgb_q[23:16];
  assign green_o       = rgb_q[15:8];
  assign blue_o        = rgb_q[7:0];
  assign last_pixel_o  = last_q;

endmodule

`default_nettype wire

[rtl/bar_meter_peak_hold_led_drawer_unit.sv]
// Bar meter drawer with peak hold: keeps a fill level and a peak marker for each
// bar and writes the matching pixels of two 8x8 LED tiles, one word per pixel.
// A level sample passes a two-word queue, is taken by the back part in its idle
// state and then runs the division steps of the two bit-serial remainder units
// that decide decay, an update step and then one pixel per cycle while the
// output is not stalled (fill rows plus the peak). Palette advances and samples
// that only count ticks are handled in the idle state of the back part; samples
// for bars that do not exist are dropped on entry. Input words are taken while
// the queue has room, also while pixels are still being written.
// Uses bmp_pkg, bmp_front, bmp_queue and bmp_back.
`default_nettype none

module bar_meter_peak_hold_led_drawer_unit #(
  parameter int unsigned NUM_BARS     = 16,
  parameter int unsigned NUM_PALETTES = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write channel.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  // Input channel.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       cmd_i,
  input  wire logic [3:0] bar_index_i,
  input  wire logic [7:0] sample_level_i,
  // Pixel channel.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            tile_select_o,
  output logic [5:0]      led_number_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic            last_pixel_o
);

  bmp_pkg::cfg_t   cfg_q;
  bmp_pkg::entry_t push_entry;
  bmp_pkg::entry_t pop_entry;
  logic            q_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_hold   <= bmp_pkg::FILL_HOLD_RST;
      cfg_q.peak_hold   <= bmp_pkg::PEAK_HOLD_RST;
      cfg_q.fill_period <= bmp_pkg::FILL_PERIOD_RST;
      cfg_q.peak_period <= bmp_pkg::PEAK_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bmp_pkg::REG_FILL_HOLD:   cfg_q.fill_hold   <= cfg_data_i;
        bmp_pkg::REG_PEAK_HOLD:   cfg_q.peak_hold   <= cfg_data_i;
        bmp_pkg::REG_FILL_PERIOD: cfg_q.fill_period <= cfg_data_i;
        bmp_pkg::REG_PEAK_PERIOD: cfg_q.peak_period <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front part: intake and classification.
  bmp_front #(
    .NUM_BARS (NUM_BARS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .bar_index_i    (bar_index_i),
    .sample_level_i (sample_level_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (push_entry)
  );

  // Queue between the two parts.
  bmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (pop_entry)
  );

  // Back part: level state and pixel writes.
  bmp_back #(
    .NUM_BARS     (NUM_BARS),
    .NUM_PALETTES (NUM_PALETTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (pop_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tile_select_o (tile_select_o),
    .led_number_o  (led_number_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

`default_nettype wire
